FILE: rtl/core/tksh_pkg.sv
// tksh_pkg: shared types and constants for the top-k score heap
// entry layout, sequencer states and fixed field widths
// no dependencies
package tksh_pkg;

  localparam int SCORE_W = 32;
  localparam int ID_W    = 31;
  localparam int CAP_W   = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_SCAN,
    S_DECIDE,
    S_POP_ROOT,
    S_POP_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_SEL,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/tksh_mem.sv
// tksh_mem: heap entry store, one write port and one read port
// read data is registered; uses entry_t from tksh_pkg
module tksh_mem import tksh_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/top_k_score_heap.sv
// top_k_score_heap: bounded max-heap of (score, id) pairs keeping the best candidates
// one shared signed comparator driven by a small sequencer; entries in tksh_mem
// depends on tksh_pkg and tksh_mem
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in_     | input     | in_valid / in_stall  | in_opcode, in_score, in_doc_id
//  out_    | output    | out_valid / out_stall| out_max_score, out_max_id, out_was_empty,
//          |           |                      | out_accepted
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_capacity
//
// one transaction at a time; in_stall stays high from acceptance until the result is
// loaded into the output register. insert: the item climbs from the end, level by level,
// until it reaches the root or is not above its parent; a full heap first scans the leaf
// half through the single read port for the smallest score and drops the item unless it
// is above it. remove: the last entry moves to the root and sinks level by level until
// no child is above it or it reaches a leaf; an empty heap reports was_empty.
// reset is synchronous and empties the heap; capacity returns to 64.
// a stalled result does not block work on the next transaction, only its delivery.
module top_k_score_heap import tksh_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [ID_W-1:0]           in_doc_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SCORE_W-1:0] out_max_score,
  output logic [ID_W-1:0]           out_max_id,
  output logic                      out_was_empty,
  output logic                      out_accepted,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CAP_W-1:0]          cfg_capacity
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = AW + 1;
  localparam int IW = AW + 2;
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  state_t state_r, state_nxt;

  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  entry_t           item_r, item_nxt;
  entry_t           cand_r, cand_nxt;
  logic [AW-1:0]    cand_idx_r, cand_idx_nxt;
  logic [CW-1:0]    scan_idx_r, scan_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic             min_vld_r, min_vld_nxt;
  logic signed [SCORE_W-1:0] min_r, min_nxt;
  logic [AW-1:0]    best_r, best_nxt;

  logic signed [SCORE_W-1:0] res_score_r, res_score_nxt;
  logic [ID_W-1:0]  res_id_r, res_id_nxt;
  logic             res_empty_r, res_empty_nxt;
  logic             res_acc_r, res_acc_nxt;

  logic             out_valid_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic [ID_W-1:0]  out_id_r;
  logic             out_empty_r;
  logic             out_acc_r;

  // memory port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr;
  entry_t        rd_q;

  // shared comparator
  logic signed [SCORE_W-1:0] cmp_a, cmp_b;
  logic                      gt;

  logic [EW-1:0] cap_ext, cap_eff;
  logic          full;
  logic [IW-1:0] lidx, ridx, cnt_ext;
  logic          l_ok, r_ok;
  logic [AW-1:0] pos_m1, parent;
  logic [CW-1:0] cnt_dec;
  logic          scan_go;
  logic          in_take;
  logic          out_free;

  tksh_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  // zero capacity behaves as one, anything above the store depth as the depth
  assign cap_ext = EW'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = EW'(1);
    end else if (cap_ext > EW'(MAX_ENTRIES)) begin
      cap_eff = EW'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end
  assign full = (EW'(cnt_r) >= cap_eff);

  assign lidx    = {1'b0, pos_r, 1'b1};
  assign ridx    = lidx + IW'(1);
  assign cnt_ext = {1'b0, cnt_r};
  assign l_ok    = (lidx < cnt_ext);
  assign r_ok    = (ridx < cnt_ext);
  assign pos_m1  = pos_r - AW'(1);
  assign parent  = pos_m1 >> 1;
  assign cnt_dec = cnt_r - CW'(1);
  assign scan_go = (scan_idx_r < cnt_r);

  assign gt = (cmp_a > cmp_b);

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_opcode == OP_INSERT) begin
            state_nxt = full ? S_SCAN : S_UP_RD;
          end else begin
            state_nxt = (cnt_r == '0) ? S_DONE : S_POP_ROOT;
          end
        end
      end
      S_UP_RD:    state_nxt = (pos_r == '0) ? S_DONE : S_UP_CMP;
      S_UP_CMP:   state_nxt = gt ? S_UP_RD : S_DONE;
      S_SCAN: begin
        if (!scan_go && !cmp_vld_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE:   state_nxt = gt ? S_UP_RD : S_DONE;
      S_POP_ROOT: state_nxt = S_POP_LAST;
      S_POP_LAST: state_nxt = (cnt_r == '0) ? S_DONE : S_DN_L;
      S_DN_L:     state_nxt = l_ok ? S_DN_R : S_DONE;
      S_DN_R:     state_nxt = r_ok ? S_DN_SEL : S_DN_CMP;
      S_DN_SEL:   state_nxt = S_DN_CMP;
      S_DN_CMP:   state_nxt = gt ? S_DN_L : S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    item_nxt      = item_r;
    cand_nxt      = cand_r;
    cand_idx_nxt  = cand_idx_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    min_vld_nxt   = min_vld_r;
    min_nxt       = min_r;
    best_nxt      = best_r;
    res_score_nxt = res_score_r;
    res_id_nxt    = res_id_r;
    res_empty_nxt = res_empty_r;
    res_acc_nxt   = res_acc_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = item_r;
    cmp_a         = '0;
    cmp_b         = '0;

    unique case (state_r)
      S_IDLE: begin
        // root is read every idle cycle so a remove finds it waiting
        if (in_take) begin
          item_nxt      = '{score: in_score, id: in_doc_id};
          res_score_nxt = '0;
          res_id_nxt    = '0;
          res_empty_nxt = 1'b0;
          res_acc_nxt   = 1'b0;
          if (in_opcode == OP_INSERT) begin
            if (full) begin
              scan_idx_nxt = cnt_r >> 1;
              cmp_vld_nxt  = 1'b0;
              min_vld_nxt  = 1'b0;
            end else begin
              pos_nxt = cnt_r[AW-1:0];
              cnt_nxt = cnt_r + CW'(1);
            end
          end else if (cnt_r == '0) begin
            res_empty_nxt = 1'b1;
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          wr_en       = 1'b1;
          res_acc_nxt = 1'b1;
        end else begin
          rd_addr = parent;
        end
      end
      S_UP_CMP: begin
        // the new item climbs through a hole; the parent moves down
        cmp_a = item_r.score;
        cmp_b = rd_q.score;
        wr_en = 1'b1;
        if (gt) begin
          wr_data = rd_q;
          pos_nxt = parent;
        end else begin
          res_acc_nxt = 1'b1;
        end
      end
      S_SCAN: begin
        cmp_a = min_r;
        cmp_b = rd_q.score;
        if (scan_go) begin
          rd_addr      = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
          cmp_idx_nxt  = scan_idx_r[AW-1:0];
          cmp_vld_nxt  = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        // strictly smaller only, so the lowest index keeps a tie
        if (cmp_vld_r && (!min_vld_r || gt)) begin
          min_nxt     = rd_q.score;
          best_nxt    = cmp_idx_r;
          min_vld_nxt = 1'b1;
        end
      end
      S_DECIDE: begin
        cmp_a = item_r.score;
        cmp_b = min_r;
        if (gt) begin
          pos_nxt = best_r;
        end
      end
      S_POP_ROOT: begin
        res_score_nxt = rd_q.score;
        res_id_nxt    = rd_q.id;
        cnt_nxt       = cnt_dec;
        rd_addr       = cnt_dec[AW-1:0];
      end
      S_POP_LAST: begin
        item_nxt = rd_q;
        pos_nxt  = '0;
      end
      S_DN_L: begin
        if (l_ok) begin
          rd_addr = lidx[AW-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end
      S_DN_R: begin
        cand_nxt     = rd_q;
        cand_idx_nxt = lidx[AW-1:0];
        if (r_ok) begin
          rd_addr = ridx[AW-1:0];
        end
      end
      S_DN_SEL: begin
        // equal children: the right one wins
        cmp_a = cand_r.score;
        cmp_b = rd_q.score;
        if (!gt) begin
          cand_nxt     = rd_q;
          cand_idx_nxt = ridx[AW-1:0];
        end
      end
      S_DN_CMP: begin
        cmp_a = cand_r.score;
        cmp_b = item_r.score;
        wr_en = 1'b1;
        if (gt) begin
          wr_data = cand_r;
          pos_nxt = cand_idx_r;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    item_r      <= item_nxt;
    cand_r      <= cand_nxt;
    cand_idx_r  <= cand_idx_nxt;
    scan_idx_r  <= scan_idx_nxt;
    cmp_vld_r   <= cmp_vld_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    min_vld_r   <= min_vld_nxt;
    min_r       <= min_nxt;
    best_r      <= best_nxt;
    res_score_r <= res_score_nxt;
    res_id_r    <= res_id_nxt;
    res_empty_r <= res_empty_nxt;
    res_acc_r   <= res_acc_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_score_r <= res_score_r;
      out_id_r    <= res_id_r;
      out_empty_r <= res_empty_r;
      out_acc_r   <= res_acc_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_max_score = out_score_r;
  assign out_max_id    = out_id_r;
  assign out_was_empty = out_empty_r;
  assign out_accepted  = out_acc_r;

endmodule

FILE: rtl/core/tksh_chk.sv
// tksh_chk: port-level checks for top_k_score_heap, bound to the top level
// depends on tksh_pkg for field widths
module tksh_chk import tksh_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [SCORE_W-1:0] out_max_score,
  input logic [ID_W-1:0]           out_max_id,
  input logic                      out_was_empty,
  input logic                      out_accepted
);

  // no result leaves the block straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one transaction at a time: accepting an input closes the input side
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input side open in the cycle after a transaction");

  // an empty remove carries no score, no id and no insert flag
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_empty) |->
      (out_max_score == '0 && out_max_id == '0 && !out_accepted))
    else $error("empty remove with payload");

  // a stored insert reports nothing popped
  a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (out_max_score == '0 && !out_was_empty))
    else $error("stored insert with popped payload");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_max_score) && $stable(out_max_id)))
    else $error("stalled result changed");

endmodule

bind top_k_score_heap tksh_chk u_tksh_chk (.*);

FILE: dv/tksh_tb_pkg.sv
`timescale 1ns / 1ps
// tksh_tb_pkg: result tracker for the top-k score heap testbench
// mirrors the heap contents and queues the results each transaction should produce
// depends on tksh_pkg
package tksh_tb_pkg;
  import tksh_pkg::*;

  localparam int HEAP_DEPTH = 64;

  typedef struct {
    logic signed [SCORE_W-1:0] max_score;
    logic [ID_W-1:0]           max_id;
    logic                      was_empty;
    logic                      accepted;
  } heap_result_t;

  class ranked_heap_tracker;
    entry_t           mirror_heap[HEAP_DEPTH];
    int               held;
    logic [CAP_W-1:0] capacity;
    heap_result_t     due_results[$];
    int unsigned      errors;

    function new();
      held     = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void swap_slots(int a, int b);
      entry_t t;
      t              = mirror_heap[a];
      mirror_heap[a] = mirror_heap[b];
      mirror_heap[b] = t;
    endfunction

    // work out the result of one accepted transaction and update the mirror
    function void note_request(logic op, logic signed [SCORE_W-1:0] score,
                               logic [ID_W-1:0] id);
      heap_result_t r;
      int           cap;
      int           pos;
      int           lowest;
      int           i;
      int           lc;
      int           rc;
      int           child;
      logic         placed;
      logic         done;
      r = '{max_score: '0, max_id: '0, was_empty: 1'b0, accepted: 1'b0};
      if (op == OP_INSERT) begin
        cap = int'(capacity);
        if (cap == 0) cap = 1;
        if (cap > HEAP_DEPTH) cap = HEAP_DEPTH;
        placed = 1'b1;
        pos    = 0;
        if (held < cap) begin
          pos  = held;
          held = held + 1;
        end else begin
          // full: smallest score in the leaf half, lowest index on ties
          lowest = held / 2;
          for (i = held / 2 + 1; i < held; i++) begin
            if ($signed(mirror_heap[i].score) < $signed(mirror_heap[lowest].score))
              lowest = i;
          end
          if (score > $signed(mirror_heap[lowest].score)) pos = lowest;
          else placed = 1'b0;
        end
        if (placed) begin
          mirror_heap[pos].score = score;
          mirror_heap[pos].id    = id;
          while (pos > 0 &&
                 $signed(mirror_heap[pos].score) > $signed(mirror_heap[(pos - 1) / 2].score))
          begin
            swap_slots(pos, (pos - 1) / 2);
            pos = (pos - 1) / 2;
          end
        end
        r.accepted = placed;
      end else if (held == 0) begin
        r.was_empty = 1'b1;
      end else begin
        r.max_score    = mirror_heap[0].score;
        r.max_id       = mirror_heap[0].id;
        held           = held - 1;
        mirror_heap[0] = mirror_heap[held];
        pos  = 0;
        done = 1'b0;
        while (!done) begin
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          if (lc >= held) begin
            done = 1'b1;
          end else begin
            // equal children go right
            child = (rc < held &&
                     !($signed(mirror_heap[lc].score) > $signed(mirror_heap[rc].score)))
                    ? rc : lc;
            if ($signed(mirror_heap[child].score) > $signed(mirror_heap[pos].score)) begin
              swap_slots(child, pos);
              pos = child;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
      due_results.push_back(r);
    endfunction

    function void check_response(logic signed [SCORE_W-1:0] max_score,
                                 logic [ID_W-1:0] max_id, logic was_empty,
                                 logic accepted);
      heap_result_t want;
      if (due_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (max_score !== want.max_score) begin
        $error("max_score: expected %0d, got %0d", want.max_score, max_score);
        errors++;
      end
      if (max_id !== want.max_id) begin
        $error("max_id: expected %0d, got %0d", want.max_id, max_id);
        errors++;
      end
      if (was_empty !== want.was_empty) begin
        $error("was_empty: expected %0b, got %0b", want.was_empty, was_empty);
        errors++;
      end
      if (accepted !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, accepted);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: testbench for top_k_score_heap, directed then random insert/remove traffic
// results checked in order against the mirror heap in ranked_heap_tracker
// depends on tksh_pkg, tksh_tb_pkg and the block's rtl
module tb_top import tksh_pkg::*, tksh_tb_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 80;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int          NUM_PHASES  = 8;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_opcode;
  logic signed [SCORE_W-1:0] in_score;
  logic [ID_W-1:0]           in_doc_id;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [SCORE_W-1:0] out_max_score;
  logic [ID_W-1:0]           out_max_id;
  logic                      out_was_empty;
  logic                      out_accepted;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CAP_W-1:0]          cfg_capacity;

  ranked_heap_tracker tracker = new();

  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;

  top_k_score_heap u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_score      (in_score),
    .in_doc_id     (in_doc_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_max_score (out_max_score),
    .out_max_id    (out_max_id),
    .out_was_empty (out_was_empty),
    .out_accepted  (out_accepted),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_capacity  (cfg_capacity)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // long receiver hold-off, counted here so the sender keeps going meanwhile
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_response(out_max_score, out_max_id, out_was_empty, out_accepted);
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(logic op, logic signed [SCORE_W-1:0] score,
                           logic [ID_W-1:0] id);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_score  <= score;
    in_doc_id <= id;
    do @(posedge clk); while (in_stall);
    tracker.note_request(op, score, id);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_drained();
    cfg_valid    <= 1'b1;
    cfg_capacity <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_capacity(value);
  endtask

  initial begin
    logic [CAP_W-1:0]          phase_cap[NUM_PHASES];
    int unsigned               phase_ins[NUM_PHASES];
    int unsigned               send_idle_pct;
    logic                      op;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
    int                        p;
    int unsigned               n;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_opcode    = OP_INSERT;
    in_score     = '0;
    in_doc_id    = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_capacity = CAP_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty remove, extremes, drop on equal score, leaf replacement
    send_item(OP_REMOVE, '0, '0);
    write_capacity(7'd3);
    send_item(OP_INSERT, 32'sh7fff_ffff, '0);
    send_item(OP_INSERT, 32'sh8000_0000, {ID_W{1'b1}});
    send_item(OP_INSERT, '0, 31'd5);
    send_item(OP_INSERT, 32'sh8000_0000, 31'd6);   // not above smallest leaf
    send_item(OP_INSERT, 32'sh0001_0000, 31'd7);
    send_item(OP_INSERT, 32'sh0001_0000, 31'd8);
    repeat (4) send_item(OP_REMOVE, SCORE_W'($urandom), ID_W'($urandom));
    // equal smallest leaves: lower index is replaced
    send_item(OP_INSERT, 32'sd5, 31'd9);
    send_item(OP_INSERT, -32'sd1, 31'd10);
    send_item(OP_INSERT, -32'sd1, 31'd11);
    send_item(OP_INSERT, 32'sd2, 31'd12);
    repeat (3) send_item(OP_REMOVE, '0, '0);
    // equal children on the way down
    write_capacity(7'd64);
    send_item(OP_INSERT, 32'sd9, 31'd1);
    send_item(OP_INSERT, 32'sd4, 31'd2);
    send_item(OP_INSERT, 32'sd4, 31'd3);
    send_item(OP_INSERT, 32'sd1, 31'd4);
    send_item(OP_REMOVE, '0, '0);
    // capacity below the count held
    write_capacity(7'd1);
    send_item(OP_INSERT, 32'sd0, 31'd20);
    send_item(OP_INSERT, 32'sd6, 31'd21);

    phase_cap = '{7'd127, 7'd3, 7'd64, 7'd0, 7'd1, 7'd16,
                  CAP_W'($urandom_range(12, 2)), CAP_W'($urandom_range(64, 1))};
    phase_ins = '{60, 75, 75, 60, 50, 70, 35, 65};

    for (p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_cap[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 48; end
        default: begin send_idle_pct = 8; recv_stall_pct <= 8; end
      endcase
      if (p == 2) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(99) < phase_ins[p]) ? OP_INSERT : OP_REMOVE;
        case ($urandom_range(3))
          0: score = SCORE_W'($urandom);
          1: score = SCORE_W'($urandom_range(15)) - 8;   // narrow range, many ties
          2: score = SCORE_W'(($urandom_range(1) ? 32'h7fff_fffc : 32'h8000_0000)
                              | $urandom_range(3));
          default: score = SCORE_W'($urandom & 32'h000f_0000);
        endcase
        id = ($urandom_range(3) == 0) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
        while ($urandom_range(99) < send_idle_pct) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        send_item(op, score, id);
      end
    end

    wait_drained();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
